// ----- design/mvl_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the MUSCL van Leer face reconstruction block.
// No dependencies; imported by every module of the block.
package mvl_pkg;

  // Default widths of the cell value and the fractional part of the value format
  localparam int DEF_VALUE_BITS    = 32;
  localparam int DEF_FRACTION_BITS = 16;

  // Width fractions are always Q0.16 with room for exactly 1.0
  localparam int FRAC_W = 17;

  // Default depth of the job queue between front and back (power of two)
  localparam int DEF_QUEUE_DEPTH = 2;

  // Control flags carried with each job
  typedef struct packed {
    logic use_slope; // differences agree in sign and are both non-zero
    logic neg;       // both differences negative: slope is negative
    logic last;      // final result of a row
  } job_flags_t;

  // Back-end sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_FRAC = 5'b01000,
    ST_DONE = 5'b10000
  } back_state_t;

endpackage

// ----- design/muscl_van_leer_face_reconstruct.sv -----
`timescale 1ns / 1ps
// MUSCL face reconstruction with the van Leer limiter: top level.
// Depends on mvl_pkg, mvl_front, mvl_queue and mvl_back.
//
// One cell value per beat enters a three-cell window; from the third cell of a row on, each
// beat yields the left state at the centre cell's right face and the right state at its left
// face, saturated to the signed value range, with row_last copied from the incoming row_end.
// A cell that gives no result (row start or window still filling) pushes no job, but it is
// held like any other while the job queue is full. A result whose two differences agree in
// sign passes through the back end as load, shift-add multiply, restoring divide, fraction
// multiply and write-back; a result with zero slope goes from load straight to write-back.
// The sustained rate is set by that single iterative back-end unit; a short job queue lets
// the front keep accepting cells while the back end works, and a result register lets the
// next job start while a result still waits to be taken.
module muscl_van_leer_face_reconstruct import mvl_pkg::*; #(
  parameter int VALUE_BITS    = DEF_VALUE_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_cell_value,
  input  logic        [FRAC_W-1:0]     in_frac_right,
  input  logic        [FRAC_W-1:0]     in_frac_left,
  input  logic                         in_row_start,
  input  logic                         in_row_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] out_left_state_right_face,
  output logic signed [VALUE_BITS-1:0] out_right_state_left_face,
  output logic                         out_row_last
);

  localparam int JOB_W = 3 * VALUE_BITS + 2 * FRAC_W + $bits(job_flags_t);

  logic             job_push;
  logic [JOB_W-1:0] job_in;
  logic             job_full;
  logic             job_pop;
  logic [JOB_W-1:0] job_out;
  logic             job_valid;

  // Window and classification
  mvl_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cell_value (in_cell_value),
    .in_frac_right (in_frac_right),
    .in_frac_left  (in_frac_left),
    .in_row_start  (in_row_start),
    .in_row_end    (in_row_end),
    .job_push      (job_push),
    .job_data      (job_in),
    .job_full      (job_full)
  );

  // Job queue between the two halves
  mvl_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .not_empty (job_valid)
  );

  // Slope, offsets and result register
  mvl_back #(
    .VALUE_BITS    (VALUE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .job_valid                 (job_valid),
    .job_data                  (job_out),
    .job_pop                   (job_pop),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_left_state_right_face (out_left_state_right_face),
    .out_right_state_left_face (out_right_state_left_face),
    .out_row_last              (out_row_last)
  );

endmodule

// ----- design/mvl_front.sv -----
`timescale 1ns / 1ps
// Front end: keeps the three-cell window, forms the differences and classifies each job.
// Depends on mvl_pkg.
module mvl_front import mvl_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  localparam int JOB_W = 3 * VALUE_BITS + 2 * FRAC_W + $bits(job_flags_t)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_cell_value,
  input  logic        [FRAC_W-1:0]     in_frac_right,
  input  logic        [FRAC_W-1:0]     in_frac_left,
  input  logic                         in_row_start,
  input  logic                         in_row_end,
  output logic                         job_push,
  output logic        [JOB_W-1:0]      job_data,
  input  logic                         job_full
);

  logic signed [VALUE_BITS-1:0] older_r, older_nxt;
  logic signed [VALUE_BITS-1:0] center_r, center_nxt;
  logic        [FRAC_W-1:0]     cfr_r, cfr_nxt;
  logic        [FRAC_W-1:0]     cfl_r, cfl_nxt;
  logic        [1:0]            fill_r, fill_nxt;

  logic                         accept;
  logic                         produce;
  logic signed [VALUE_BITS:0]   dl;
  logic signed [VALUE_BITS:0]   dr;
  logic        [VALUE_BITS:0]   dl_abs;
  logic        [VALUE_BITS:0]   dr_abs;
  job_flags_t                   flags;

  // Hold the input while the queue has no room
  assign in_stall = job_full;
  assign accept   = in_valid && !in_stall;
  assign produce  = !in_row_start && fill_r[1];

  // Backward and forward differences, exact in one extra bit
  assign dl = {center_r[VALUE_BITS-1], center_r} - {older_r[VALUE_BITS-1], older_r};
  assign dr = {in_cell_value[VALUE_BITS-1], in_cell_value}
            - {center_r[VALUE_BITS-1], center_r};
  assign dl_abs = dl[VALUE_BITS] ? -dl : dl;
  assign dr_abs = dr[VALUE_BITS] ? -dr : dr;

  // Classify: a slope is formed only when both differences are non-zero and share a sign
  always_comb begin
    flags.use_slope = (dl != '0) && (dr != '0) && (dl[VALUE_BITS] == dr[VALUE_BITS]);
    flags.neg       = dl[VALUE_BITS];
    flags.last      = in_row_end;
  end

  assign job_push = accept && produce;
  assign job_data = {center_r, dl_abs[VALUE_BITS-1:0], dr_abs[VALUE_BITS-1:0],
                     cfr_r, cfl_r, flags};

  // Advance the window on every accepted beat
  always_comb begin
    older_nxt  = older_r;
    center_nxt = center_r;
    cfr_nxt    = cfr_r;
    cfl_nxt    = cfl_r;
    fill_nxt   = fill_r;
    if (accept) begin
      older_nxt  = center_r;
      center_nxt = in_cell_value;
      cfr_nxt    = in_frac_right;
      cfl_nxt    = in_frac_left;
      if (in_row_start) begin
        fill_nxt = 2'd1;
      end else if (!fill_r[1]) begin
        fill_nxt = fill_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    older_r  <= older_nxt;
    center_r <= center_nxt;
    cfr_r    <= cfr_nxt;
    cfl_r    <= cfl_nxt;
  end

endmodule

// ----- design/mvl_queue.sv -----
`timescale 1ns / 1ps
// Short register queue that decouples the front end from the back end.
// Depends on mvl_pkg for the default depth.
module mvl_queue import mvl_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write the entry on push
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/mvl_back.sv -----
`timescale 1ns / 1ps
// Back end: iterative slope multiply and divide, fraction offsets, saturation, result register.
// Depends on mvl_pkg.
module mvl_back import mvl_pkg::*; #(
  parameter int VALUE_BITS    = DEF_VALUE_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  localparam int JOB_W = 3 * VALUE_BITS + 2 * FRAC_W + $bits(job_flags_t)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  input  logic        [JOB_W-1:0]      job_data,
  output logic                         job_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] out_left_state_right_face,
  output logic signed [VALUE_BITS-1:0] out_right_state_left_face,
  output logic                         out_row_last
);

  localparam int VB    = VALUE_BITS;
  localparam int CNT_W = $clog2(VB + 1);
  localparam int PW    = FRAC_W + VB + 1;        // fraction times slope
  localparam int OW    = PW - FRACTION_BITS;     // offset after the shift
  localparam int SUMW  = VB + FRAC_W + 2;        // face value before clamping
  localparam logic signed [SUMW-1:0] MAX_S = {{(SUMW-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [SUMW-1:0] MIN_S = {{(SUMW-VB+1){1'b1}}, {(VB-1){1'b0}}};

  back_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic signed [VB-1:0] c_r, c_nxt;
  logic [VB-1:0]        a_r, a_nxt;
  logic [VB-1:0]        b_r, b_nxt;
  logic [VB:0]          d_r, d_nxt;
  logic [2*VB-1:0]      prod_r, prod_nxt;
  logic [VB:0]          rem_r, rem_nxt;
  logic [VB:0]          nsh_r, nsh_nxt;
  logic [VB:0]          quo_r, quo_nxt;
  logic [FRAC_W-1:0]    fr_r, fr_nxt;
  logic [FRAC_W-1:0]    fl_r, fl_nxt;
  logic [PW-1:0]        tr_r, tr_nxt;
  logic [PW-1:0]        tl_r, tl_nxt;
  job_flags_t           flags_r, flags_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [VB-1:0] lsrf_r, lsrf_nxt;
  logic signed [VB-1:0] rslf_r, rslf_nxt;
  logic                 last_r, last_nxt;

  logic signed [VB-1:0] j_center;
  logic [VB-1:0]        j_a;
  logic [VB-1:0]        j_b;
  logic [FRAC_W-1:0]    j_fr;
  logic [FRAC_W-1:0]    j_fl;
  job_flags_t           j_flags;

  logic [2*VB-1:0]      mul_step;
  logic [VB+1:0]        div_trial;
  logic [VB+1:0]        div_diff;
  logic                 div_ge;
  logic [PW-1:0]        slope_ext;
  logic [PW-1:0]        tr_step;
  logic [PW-1:0]        tl_step;
  logic [PW-1:0]        tr_shift;
  logic [PW-1:0]        tl_shift;
  logic signed [SUMW-1:0] c_ext;
  logic signed [SUMW-1:0] off_r_ext;
  logic signed [SUMW-1:0] off_l_ext;
  logic signed [SUMW-1:0] face_r;
  logic signed [SUMW-1:0] face_l;
  logic                 out_free;

  // Unpack the job
  assign {j_center, j_a, j_b, j_fr, j_fl, j_flags} = job_data;

  // Clamp a face value to the signed value range
  function automatic logic signed [VB-1:0] clamp(input logic signed [SUMW-1:0] x);
    logic signed [SUMW-1:0] y;
    begin
      if (x > MAX_S) begin
        y = MAX_S;
      end else if (x < MIN_S) begin
        y = MIN_S;
      end else begin
        y = x;
      end
      clamp = y[VB-1:0];
    end
  endfunction

  // Datapath steps: shift-add multiply, restoring divide, fraction multiply
  assign mul_step  = {prod_r[2*VB-2:0], 1'b0} + (b_r[VB-1] ? {{VB{1'b0}}, a_r} : '0);
  assign div_trial = {rem_r, nsh_r[VB]};
  assign div_diff  = div_trial - {1'b0, d_r};
  assign div_ge    = (div_trial >= {1'b0, d_r});
  assign slope_ext = {{(PW-VB-1){1'b0}}, quo_r};
  assign tr_step   = {tr_r[PW-2:0], 1'b0} + (fr_r[FRAC_W-1] ? slope_ext : '0);
  assign tl_step   = {tl_r[PW-2:0], 1'b0} + (fl_r[FRAC_W-1] ? slope_ext : '0);

  // Offsets applied with the slope sign
  assign tr_shift  = tr_r >> FRACTION_BITS;
  assign tl_shift  = tl_r >> FRACTION_BITS;
  assign c_ext     = {{(SUMW-VB){c_r[VB-1]}}, c_r};
  assign off_r_ext = {{(SUMW-OW){1'b0}}, tr_shift[OW-1:0]};
  assign off_l_ext = {{(SUMW-OW){1'b0}}, tl_shift[OW-1:0]};
  assign face_r    = flags_r.neg ? c_ext - off_r_ext : c_ext + off_r_ext;
  assign face_l    = flags_r.neg ? c_ext + off_l_ext : c_ext - off_l_ext;

  assign out_free  = !out_valid_r || !out_stall;
  assign job_pop   = (state_r == ST_IDLE) && job_valid;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    c_nxt         = c_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    d_nxt         = d_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    nsh_nxt       = nsh_r;
    quo_nxt       = quo_r;
    fr_nxt        = fr_r;
    fl_nxt        = fl_r;
    tr_nxt        = tr_r;
    tl_nxt        = tl_r;
    flags_nxt     = flags_r;
    out_valid_nxt = out_valid_r && out_stall;
    lsrf_nxt      = lsrf_r;
    rslf_nxt      = rslf_r;
    last_nxt      = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          c_nxt     = j_center;
          a_nxt     = j_a;
          b_nxt     = j_b;
          d_nxt     = {1'b0, j_a} + {1'b0, j_b};
          fr_nxt    = j_fr;
          fl_nxt    = j_fl;
          flags_nxt = j_flags;
          tr_nxt    = '0;
          tl_nxt    = '0;
          prod_nxt  = '0;
          cnt_nxt   = CNT_W'(VB - 1);
          state_nxt = j_flags.use_slope ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        prod_nxt = mul_step;
        b_nxt    = {b_r[VB-2:0], 1'b0};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          // Numerator is twice the product; high part seeds the remainder
          rem_nxt   = {1'b0, mul_step[2*VB-1:VB]};
          nsh_nxt   = {mul_step[VB-1:0], 1'b0};
          quo_nxt   = '0;
          cnt_nxt   = CNT_W'(VB);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? div_diff[VB:0] : div_trial[VB:0];
        nsh_nxt = {nsh_r[VB-1:0], 1'b0};
        quo_nxt = {quo_r[VB-1:0], div_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(FRAC_W - 1);
          state_nxt = ST_FRAC;
        end
      end
      ST_FRAC: begin
        tr_nxt  = tr_step;
        tl_nxt  = tl_step;
        fr_nxt  = {fr_r[FRAC_W-2:0], 1'b0};
        fl_nxt  = {fl_r[FRAC_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Write the result once the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          lsrf_nxt      = clamp(face_r);
          rslf_nxt      = clamp(face_l);
          last_nxt      = flags_r.last;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    c_r     <= c_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    d_r     <= d_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    nsh_r   <= nsh_nxt;
    quo_r   <= quo_nxt;
    fr_r    <= fr_nxt;
    fl_r    <= fl_nxt;
    tr_r    <= tr_nxt;
    tl_r    <= tl_nxt;
    flags_r <= flags_nxt;
    lsrf_r  <= lsrf_nxt;
    rslf_r  <= rslf_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid                 = out_valid_r;
  assign out_left_state_right_face = lsrf_r;
  assign out_right_state_left_face = rslf_r;
  assign out_row_last              = last_r;

endmodule
